>>> src/pvd_pkg.sv
// ----------------------------------------------------------------------------
// pvd_pkg: shared types and constants of the polynomial value/slope unit
// Holds the fixed-point widths, register count and the record that travels
// from cell to cell along the Horner chain.
// ----------------------------------------------------------------------------
`default_nettype none

package pvd_pkg;

    // Signed Q16.16 data word.
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * DATA_W;
    // A product shifted right by the fraction bits keeps this many bits.
    localparam int SHPROD_W  = PROD_W - FRAC_W;
    // Sum of a data word and a shifted product, one guard bit on top.
    localparam int SUM_W     = SHPROD_W + 1;

    // Coefficient register file.
    localparam int NUM_REGS  = 8;
    localparam int REG_SEL_W = 3;
    localparam int REG_IDX_W = 4;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Partial result handed from one Horner cell to the next.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] slope;
        logic signed [DATA_W-1:0] arg;
        logic                     ovf;
    } t_stage;

endpackage

`default_nettype wire

>>> src/pvd_cell.sv
// ----------------------------------------------------------------------------
// pvd_cell: one Horner step for value and slope
// Stage one forms the products value*x and slope*x; stage two adds the
// coefficient and the old value to the shifted products and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module pvd_cell (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire pvd_pkg::t_stage                    i_stage,
    input  wire logic signed [pvd_pkg::DATA_W-1:0]  i_coef,
    output      logic                               o_valid,
    output      pvd_pkg::t_stage                    o_stage
);

    // Clamp a wide sum to the data range; the top bit flags saturation.
    function automatic logic [pvd_pkg::DATA_W:0] sat_word(
        input logic [pvd_pkg::SUM_W-1:0] s
    );
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &s[pvd_pkg::SUM_W-1:pvd_pkg::DATA_W-1];
        hi_zeros = ~|s[pvd_pkg::SUM_W-1:pvd_pkg::DATA_W-1];
        if (hi_ones || hi_zeros) begin
            sat_word = {1'b0, s[pvd_pkg::DATA_W-1:0]};
        end else if (s[pvd_pkg::SUM_W-1]) begin
            sat_word = {1'b1, pvd_pkg::SAT_MIN};
        end else begin
            sat_word = {1'b1, pvd_pkg::SAT_MAX};
        end
    endfunction

    logic signed [pvd_pkg::PROD_W-1:0] r_pv;
    logic signed [pvd_pkg::PROD_W-1:0] r_ps;
    logic signed [pvd_pkg::PROD_W-1:0] n_pv;
    logic signed [pvd_pkg::PROD_W-1:0] n_ps;
    logic signed [pvd_pkg::DATA_W-1:0] r_val1;
    logic signed [pvd_pkg::DATA_W-1:0] r_arg1;
    logic                              r_ovf1;
    logic                              r_vld1;
    logic [pvd_pkg::SUM_W-1:0]         sum_val;
    logic [pvd_pkg::SUM_W-1:0]         sum_slp;
    logic [pvd_pkg::DATA_W:0]          sat_val;
    logic [pvd_pkg::DATA_W:0]          sat_slp;
    pvd_pkg::t_stage                   n_stage;
    pvd_pkg::t_stage                   r_stage;
    logic                              r_vld2;

    // Stage one: full-width signed products against the argument.
    always_comb begin
        n_pv = {{pvd_pkg::DATA_W{i_stage.value[pvd_pkg::DATA_W-1]}}, i_stage.value}
             * {{pvd_pkg::DATA_W{i_stage.arg[pvd_pkg::DATA_W-1]}}, i_stage.arg};
        n_ps = {{pvd_pkg::DATA_W{i_stage.slope[pvd_pkg::DATA_W-1]}}, i_stage.slope}
             * {{pvd_pkg::DATA_W{i_stage.arg[pvd_pkg::DATA_W-1]}}, i_stage.arg};
    end

    always_ff @(posedge i_clk) begin
        r_pv   <= n_pv;
        r_ps   <= n_ps;
        r_val1 <= i_stage.value;
        r_arg1 <= i_stage.arg;
        r_ovf1 <= i_stage.ovf;
    end

    // Stage two: floor shift of the products, add, saturate.
    // The slope uses the value from before this step's update.
    always_comb begin
        sum_val = {{(pvd_pkg::SUM_W-pvd_pkg::DATA_W){i_coef[pvd_pkg::DATA_W-1]}}, i_coef}
                + {r_pv[pvd_pkg::PROD_W-1], r_pv[pvd_pkg::PROD_W-1:pvd_pkg::FRAC_W]};
        sum_slp = {{(pvd_pkg::SUM_W-pvd_pkg::DATA_W){r_val1[pvd_pkg::DATA_W-1]}}, r_val1}
                + {r_ps[pvd_pkg::PROD_W-1], r_ps[pvd_pkg::PROD_W-1:pvd_pkg::FRAC_W]};
        sat_val = sat_word(sum_val);
        sat_slp = sat_word(sum_slp);
        n_stage.value = sat_val[pvd_pkg::DATA_W-1:0];
        n_stage.slope = sat_slp[pvd_pkg::DATA_W-1:0];
        n_stage.arg   = r_arg1;
        n_stage.ovf   = r_ovf1 | sat_val[pvd_pkg::DATA_W] | sat_slp[pvd_pkg::DATA_W];
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    // Valid bits follow the data through both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    assign o_valid = r_vld2;
    assign o_stage = r_stage;

    // An item entering the cell leaves it after both register stages.
    a_valid_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##2 o_valid)
        else $error("pvd_cell: item lost in cell");

    // A saturation seen upstream is never dropped.
    a_ovf_sticky: assert property (@(posedge i_clk)
        i_stage.ovf |-> ##2 o_stage.ovf)
        else $error("pvd_cell: overflow flag dropped");

    // The argument travels with its item unchanged.
    a_arg_carried: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##2 (o_stage.arg == $past(i_stage.arg, 2)))
        else $error("pvd_cell: argument corrupted");

endmodule

`default_nettype wire

>>> src/polynomial_value_and_derivative_unit.sv
// ----------------------------------------------------------------------------
// polynomial_value_and_derivative_unit: p(x) and p'(x) by Horner's rule
// A chain of Horner cells evaluates a polynomial of up to eight signed
// Q16.16 coefficients and its derivative at one argument per cycle.
// ----------------------------------------------------------------------------
// The unit takes one argument on every cycle in which start is high; busy
// stays low, so items may follow each other without gaps. Each item passes
// through NUM_COEFFS-1 Horner cells of two register stages each (multiply,
// then add and saturate) before its result appears, with o_valid high
// for one cycle. The receiver cannot stall the unit: results must be
// taken when shown. Coefficients are written through the configuration port
// and must only change while no item is in flight; writes to indexes eight
// and above are ignored, as are coefficients at or above NUM_COEFFS.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_value_and_derivative_unit #(
    parameter int NUM_COEFFS = 8
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Configuration write port.
    input  wire logic                                  i_cfg_we,
    input  wire logic [pvd_pkg::REG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [pvd_pkg::DATA_W-1:0]            i_cfg_wdata,
    // Command side.
    input  wire logic                                  start,
    output      logic                                  busy,
    input  wire logic signed [pvd_pkg::DATA_W-1:0]     i_arg_x,
    // Result side.
    output      logic                                  o_valid,
    output      logic signed [pvd_pkg::DATA_W-1:0]     o_poly_value,
    output      logic signed [pvd_pkg::DATA_W-1:0]     o_poly_slope,
    output      logic                                  o_overflow
);

    localparam int NUM_CELLS = NUM_COEFFS - 1;
    localparam int LATENCY   = 2 * NUM_CELLS;

    logic signed [pvd_pkg::DATA_W-1:0] r_coef [pvd_pkg::NUM_REGS];
    pvd_pkg::t_stage                   stage  [NUM_CELLS+1];
    logic                              vld    [NUM_CELLS+1];
    logic                              accept;

    // Coefficient registers; out-of-range indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pvd_pkg::NUM_REGS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_idx < pvd_pkg::REG_IDX_W'(pvd_pkg::NUM_REGS))) begin
            r_coef[i_cfg_idx[pvd_pkg::REG_SEL_W-1:0]] <= i_cfg_wdata;
        end
    end

    // The pipeline takes an item in every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Head of the chain: value starts at the top coefficient, slope at zero.
    always_comb begin
        vld[0]         = accept;
        stage[0].value = r_coef[NUM_COEFFS-1];
        stage[0].slope = '0;
        stage[0].arg   = i_arg_x;
        stage[0].ovf   = 1'b0;
    end

    // One cell per lower coefficient, in descending order.
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        pvd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[k]),
            .i_stage (stage[k]),
            .i_coef  (r_coef[NUM_COEFFS-2-k]),
            .o_valid (vld[k+1]),
            .o_stage (stage[k+1])
        );
    end

    // The last cell's registers drive the result ports.
    assign o_valid      = vld[NUM_CELLS];
    assign o_poly_value = stage[NUM_CELLS].value;
    assign o_poly_slope = stage[NUM_CELLS].slope;
    assign o_overflow   = stage[NUM_CELLS].ovf;

    // Every accepted item produces its result once it has passed through every cell.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("pvd: result missing after pipeline latency");

    // The sender is never held off.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("pvd: busy raised");

    // The result strobe is a known level once out of reset.
    a_valid_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(o_valid))
        else $error("pvd: result strobe unknown");

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for polynomial_value_and_derivative_unit
// Loads coefficient sets through the configuration port and sends arguments
// with random gaps. A Horner predictor in the bench computes the expected
// value, slope and overflow flag of every item, and a checker compares each
// strobed result with the oldest expectation.
// ----------------------------------------------------------------------------

module tb;

    localparam int NUM_COEFFS       = 8;
    localparam int CLK_HALF_NS      = 10;
    localparam int RESET_CYCLES     = 5;
    localparam int PIPE_LAT         = 2 * (NUM_COEFFS - 1);
    localparam int RANDOM_PER_PHASE = 376;
    localparam int TIMEOUT_NS       = 4_000_000;
    localparam int ONE_Q            = 1 << pvd_pkg::FRAC_W;
    localparam int LAST_IDX         = (1 << pvd_pkg::REG_IDX_W) - 1;

    // Magnitude classes used when drawing random words.
    typedef enum int {
        MAG_SMALL,
        MAG_FULL,
        MAG_EXTREME
    } t_mag;

    typedef struct {
        logic signed [pvd_pkg::DATA_W-1:0] value;
        logic signed [pvd_pkg::DATA_W-1:0] slope;
        logic                              ovf;
    } t_horner_result;

    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_cfg_we    = 1'b0;
    logic [pvd_pkg::REG_IDX_W-1:0]        i_cfg_idx   = '0;
    logic [pvd_pkg::DATA_W-1:0]           i_cfg_wdata = '0;
    logic                                 start       = 1'b0;
    logic                                 busy;
    logic signed [pvd_pkg::DATA_W-1:0]    i_arg_x     = '0;
    logic                                 o_valid;
    logic signed [pvd_pkg::DATA_W-1:0]    o_poly_value;
    logic signed [pvd_pkg::DATA_W-1:0]    o_poly_slope;
    logic                                 o_overflow;

    // Bench copy of the coefficient registers and the set about to be loaded.
    logic signed [pvd_pkg::DATA_W-1:0] coef_shadow [pvd_pkg::NUM_REGS] = '{default: '0};
    logic signed [pvd_pkg::DATA_W-1:0] coef_plan   [pvd_pkg::NUM_REGS] = '{default: '0};

    t_horner_result              pending_results [$];

    int items_sent      = 0;
    int results_checked = 0;
    int saturated_seen  = 0;
    int reg_writes      = 0;
    int mismatches      = 0;

    polynomial_value_and_derivative_unit #(
        .NUM_COEFFS (NUM_COEFFS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .start        (start),
        .busy         (busy),
        .i_arg_x      (i_arg_x),
        .o_valid      (o_valid),
        .o_poly_value (o_poly_value),
        .o_poly_slope (o_poly_slope),
        .o_overflow   (o_overflow)
    );

    // Free-running clock.
    initial begin
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    // Hard stop in case the unit hangs or drops results.
    initial begin
        #TIMEOUT_NS;
        $display("timeout with %0d results still pending", pending_results.size());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Horner predictor
    // ------------------------------------------------------------------

    // Full-width product, shifted down with floor rounding.
    function automatic longint q_mul(input longint a, input longint b);
        return (a * b) >>> pvd_pkg::FRAC_W;
    endfunction

    // Clamp an exact sum to 32 bits and note any clipping.
    function automatic longint clamp_q(input longint s, inout bit hit);
        if (s > longint'(pvd_pkg::SAT_MAX)) begin
            hit = 1'b1;
            return longint'(pvd_pkg::SAT_MAX);
        end
        if (s < longint'(pvd_pkg::SAT_MIN)) begin
            hit = 1'b1;
            return longint'(pvd_pkg::SAT_MIN);
        end
        return s;
    endfunction

    function automatic t_horner_result eval_horner(
        input logic signed [pvd_pkg::DATA_W-1:0] x
    );
        t_horner_result r;
        longint         xs;
        longint         acc_val;
        longint         acc_slope;
        bit             hit;
        int             k;
        xs        = longint'(x);
        acc_val   = longint'(coef_shadow[NUM_COEFFS-1]);
        acc_slope = 0;
        hit       = 1'b0;
        // The slope update must see the value from before this step.
        for (k = NUM_COEFFS - 2; k >= 0; k--) begin
            acc_slope = clamp_q(acc_val + q_mul(acc_slope, xs), hit);
            acc_val   = clamp_q(longint'(coef_shadow[k]) + q_mul(acc_val, xs), hit);
        end
        r.value = acc_val[pvd_pkg::DATA_W-1:0];
        r.slope = acc_slope[pvd_pkg::DATA_W-1:0];
        r.ovf   = hit;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [pvd_pkg::DATA_W-1:0] rand_word(input t_mag mag);
        int v;
        int bits;
        case (mag)
            MAG_SMALL: begin
                // Sign-extend a short random field so that both signs appear.
                bits = $urandom_range(20, 10);
                v    = $urandom;
                v    = v <<< (pvd_pkg::DATA_W - bits);
                v    = v >>> (pvd_pkg::DATA_W - bits);
            end
            MAG_FULL: begin
                v = $urandom;
            end
            default: begin
                case ($urandom_range(6))
                    0:       v = pvd_pkg::SAT_MAX;
                    1:       v = pvd_pkg::SAT_MIN;
                    2:       v = 0;
                    3:       v = 1;
                    4:       v = -1;
                    5:       v = ONE_Q;
                    default: v = -ONE_Q;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [pvd_pkg::DATA_W-1:0] rand_arg();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            return rand_word(MAG_SMALL);
        end else if (r < 90) begin
            return rand_word(MAG_FULL);
        end
        return rand_word(MAG_EXTREME);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Sends one argument after a random number of idle cycles and records
    // the expected result once the item is taken.
    task automatic send_arg(input logic signed [pvd_pkg::DATA_W-1:0] x, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_arg_x <= x;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        pending_results.push_back(eval_horner(x));
        items_sent++;
    endtask

    // Stops sending and lets every item in flight come out.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LAT) @(posedge i_clk);
    endtask

    // One register write; the enable stays high until release_cfg.
    task automatic write_reg(input int idx, input logic [pvd_pkg::DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= pvd_pkg::REG_IDX_W'(idx);
        i_cfg_wdata <= data;
        @(posedge i_clk);
        if (idx < pvd_pkg::NUM_REGS) begin
            coef_shadow[idx] = data;
        end
        reg_writes++;
    endtask

    task automatic release_cfg();
        i_cfg_we <= 1'b0;
    endtask

    // Writes the planned coefficients selected by the mask, optionally
    // followed by a write to an index that does not exist.
    task automatic load_coefs(input bit [pvd_pkg::NUM_REGS-1:0] mask, input bit junk);
        int k;
        for (k = 0; k < pvd_pkg::NUM_REGS; k++) begin
            if (mask[k]) begin
                write_reg(k, coef_plan[k]);
            end
        end
        if (junk) begin
            write_reg($urandom_range(LAST_IDX, pvd_pkg::NUM_REGS), $urandom);
        end
        release_cfg();
    endtask

    task automatic plan_random_coefs();
        int   r;
        int   top;
        int   k;
        t_mag mag;
        r   = $urandom_range(99);
        top = (r >= 85) ? $urandom_range(pvd_pkg::NUM_REGS - 1) : pvd_pkg::NUM_REGS - 1;
        for (k = 0; k < pvd_pkg::NUM_REGS; k++) begin
            if (r < 50 || r >= 85) begin
                mag = MAG_SMALL;
            end else if (r < 70) begin
                mag = MAG_FULL;
            end else begin
                mag = t_mag'($urandom_range(2));
            end
            coef_plan[k] = (k <= top) ? rand_word(mag) : '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // All coefficients are zero after reset, so every result is zero.
    task automatic test_reset_state();
        send_arg('0, 0);
        send_arg($urandom, 0);
        send_arg(pvd_pkg::SAT_MIN, 0);
    endtask

    // Writes above the last register must not alias onto a real one.
    task automatic test_register_index_range();
        int k;
        wait_idle();
        for (k = 0; k < pvd_pkg::NUM_REGS; k++) begin
            coef_plan[k] = (k + 1) * ONE_Q;
        end
        load_coefs('1, 1'b0);
        for (k = pvd_pkg::NUM_REGS; k <= LAST_IDX; k++) begin
            write_reg(k, $urandom);
        end
        release_cfg();
        send_arg(ONE_Q, 0);
    endtask

    // p(x) = 1 + 2x + ... + 8x^7 at simple and extreme points.
    task automatic test_known_polynomial();
        int k;
        wait_idle();
        for (k = 0; k < pvd_pkg::NUM_REGS; k++) begin
            coef_plan[k] = (k + 1) * ONE_Q;
        end
        load_coefs('1, 1'b0);
        send_arg('0, 0);
        send_arg(ONE_Q, 0);
        send_arg(-ONE_Q, 0);
        send_arg(ONE_Q / 2, 0);
        send_arg(1, 0);
        send_arg(-1, 0);
        send_arg(pvd_pkg::SAT_MAX, 0);
        send_arg(pvd_pkg::SAT_MIN, 0);
    endtask

    // Extreme coefficients clip in the middle of the chain.
    task automatic test_saturation();
        int k;
        wait_idle();
        for (k = 0; k < pvd_pkg::NUM_REGS; k++) begin
            coef_plan[k] = pvd_pkg::SAT_MAX;
        end
        load_coefs('1, 1'b0);
        send_arg(ONE_Q, 0);
        send_arg(-ONE_Q, 0);
        send_arg(pvd_pkg::SAT_MIN, 0);
        wait_idle();
        for (k = 0; k < pvd_pkg::NUM_REGS; k++) begin
            coef_plan[k] = pvd_pkg::SAT_MIN;
        end
        load_coefs('1, 1'b0);
        send_arg(ONE_Q, 0);
        send_arg(pvd_pkg::SAT_MAX, 0);
        send_arg('0, 0);
    endtask

    // Zero high coefficients leave a straight line: 3 - 2x.
    task automatic test_short_degree();
        int k;
        wait_idle();
        for (k = 0; k < pvd_pkg::NUM_REGS; k++) begin
            coef_plan[k] = '0;
        end
        coef_plan[0] = 3 * ONE_Q;
        coef_plan[1] = -2 * ONE_Q;
        load_coefs('1, 1'b0);
        send_arg(ONE_Q, 0);
        send_arg(rand_word(MAG_SMALL), 0);
        send_arg(rand_word(MAG_FULL), 0);
    endtask

    // Groups of random arguments, each under a freshly drawn coefficient set.
    task automatic test_random_mix(input int n_items, input int idle_pct);
        int                         left;
        int                         grp;
        bit [pvd_pkg::NUM_REGS-1:0] mask;
        bit                         junk;
        left = n_items;
        while (left > 0) begin
            wait_idle();
            plan_random_coefs();
            mask = ($urandom_range(99) < 80) ? '1 : pvd_pkg::NUM_REGS'($urandom);
            junk = ($urandom_range(99) < 15);
            load_coefs(mask, junk);
            grp = $urandom_range(60, 15);
            if (grp > left) begin
                grp = left;
            end
            repeat (grp) send_arg(rand_arg(), idle_pct);
            left -= grp;
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_horner_result want;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result strobe with no item pending");
                end else begin
                    want = pending_results.pop_front();
                    if (o_poly_value !== want.value) begin
                        report_mismatch($sformatf("poly_value got %h expected %h",
                                                  o_poly_value, want.value));
                    end
                    if (o_poly_slope !== want.slope) begin
                        report_mismatch($sformatf("poly_slope got %h expected %h",
                                                  o_poly_slope, want.slope));
                    end
                    if (o_overflow !== want.ovf) begin
                        report_mismatch($sformatf("overflow got %b expected %b",
                                                  o_overflow, want.ovf));
                    end
                    results_checked++;
                    if (want.ovf) begin
                        saturated_seen++;
                    end
                end
            end else if (o_valid !== 1'b0) begin
                report_mismatch("result strobe is unknown");
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_register_index_range();
        test_known_polynomial();
        test_saturation();
        test_short_degree();
        test_random_mix(RANDOM_PER_PHASE, 10);
        test_random_mix(RANDOM_PER_PHASE, 86);
        test_random_mix(RANDOM_PER_PHASE, 0);

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end

        $display("sent %0d items and checked %0d results, %0d of them saturated",
                 items_sent, results_checked, saturated_seen);
        $display("made %0d register writes under three gap profiles, %0d mismatches",
                 reg_writes, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
